@@ rtl/ptdr_pkg.sv @@
// ----------------------------------------------------------------------------
// ptdr_pkg: shared definitions for the pointer tap/drag recogniser
// Field widths, gesture codes and register indexes used by the top level and
// the coordinate scaler.
// ----------------------------------------------------------------------------
package ptdr_pkg;

	// Item field widths
	localparam int unsigned MASK_W   = 8;
	localparam int unsigned POS_W    = 16;
	localparam int unsigned SCALE_W  = 18;
	localparam int unsigned COORD_W  = 17;
	localparam int unsigned GEST_W   = 2;
	localparam int unsigned FRAC_W   = 16;
	localparam int unsigned PROD_W   = POS_W + SCALE_W;

	// Packed stream widths, rounded up to whole bytes
	localparam int unsigned IN_W     = MASK_W + 2 * POS_W;
	localparam int unsigned IN_BYTES = (IN_W + 7) / 8;
	localparam int unsigned OUT_W    = GEST_W + 4 * COORD_W;
	localparam int unsigned OUT_BYTES = (OUT_W + 7) / 8;

	// Saturation ceiling for a reported coordinate
	localparam logic [COORD_W-1:0] COORD_MAX = '1;

	// Gesture codes
	typedef enum logic [GEST_W-1:0] {
		GEST_NONE = 2'd0,
		GEST_TAP  = 2'd1,
		GEST_DRAG = 2'd2
	} gesture_t;

	// Configuration register indexes (byte address = 4 * index)
	localparam int unsigned REG_IDX_W = 2;
	typedef enum logic [REG_IDX_W-1:0] {
		REG_SCREEN_WIDTH  = 2'd0,
		REG_SCREEN_HEIGHT = 2'd1,
		REG_INV_SCALE     = 2'd2
	} reg_idx_t;

	// Reset values of the configuration registers
	localparam logic [POS_W-1:0]   SCREEN_WIDTH_RST  = 16'd1024;
	localparam logic [POS_W-1:0]   SCREEN_HEIGHT_RST = 16'd768;
	localparam logic [SCALE_W-1:0] INV_SCALE_RST     = 18'd32768;

endpackage

@@ rtl/ptdr_scale.sv @@
// ----------------------------------------------------------------------------
// ptdr_scale: coordinate scaler
// Multiplies a pixel coordinate by a Q2.16 reciprocal, drops the fraction
// and saturates to the reported coordinate width.
// ----------------------------------------------------------------------------
module ptdr_scale (
	input  logic [ptdr_pkg::POS_W-1:0]   coord,
	input  logic [ptdr_pkg::SCALE_W-1:0] inv_scale,
	output logic [ptdr_pkg::COORD_W-1:0] scaled
);

	logic [ptdr_pkg::PROD_W-1:0]                   product;
	logic [ptdr_pkg::PROD_W-ptdr_pkg::FRAC_W-1:0]  whole;

	// Full product, then integer part
	assign product = {{ptdr_pkg::SCALE_W{1'b0}}, coord} *
	                 {{ptdr_pkg::POS_W{1'b0}}, inv_scale};
	assign whole   = product[ptdr_pkg::PROD_W-1:ptdr_pkg::FRAC_W];

	// Clamp anything beyond the coordinate range
	always_comb begin
		if (whole[ptdr_pkg::PROD_W-ptdr_pkg::FRAC_W-1:ptdr_pkg::COORD_W] != '0) begin
			scaled = ptdr_pkg::COORD_MAX;
		end else begin
			scaled = whole[ptdr_pkg::COORD_W-1:0];
		end
	end

endmodule

@@ rtl/pointer_tap_drag_recognizer.sv @@
// ----------------------------------------------------------------------------
// pointer_tap_drag_recognizer: tap and drag gestures from pointer events
// Input register, then gesture decision and scaling into the result register.
// ----------------------------------------------------------------------------
// Every accepted pointer event yields exactly one result item, which goes
// from the input register to the output register. One event can be taken
// every cycle while the output is not stalled. The gesture state (drag phase,
// start point, tap flag, last position) is read and updated as an event
// leaves the input register, so back-to-back events see each other's effects.
// The four coordinate multipliers sit between the gesture decision and the
// output register. Events with a mask above 1 or outside the screen give
// a result with no gesture and change no state. Configuration must be
// written only while the pipeline is empty; the block does not enforce it.
module pointer_tap_drag_recognizer (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Event stream in
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// button_mask[7:0], pos_x[23:8], pos_y[39:24]
	input  logic [8*ptdr_pkg::IN_BYTES-1:0]      s_tdata,
	// Gesture stream out
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// gesture[1:0], from_x[18:2], from_y[35:19], to_x[52:36], to_y[69:53]
	output logic [8*ptdr_pkg::OUT_BYTES-1:0]     m_tdata,
	// Configuration port
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [ptdr_pkg::REG_IDX_W+1:0]       paddr,
	input  logic [31:0]                          pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready
);

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_PRESSED = 2'd1,
		PH_MOVED   = 2'd2
	} phase_t;

	// Configuration registers
	logic [ptdr_pkg::POS_W-1:0]   screen_width_q;
	logic [ptdr_pkg::POS_W-1:0]   screen_height_q;
	logic [ptdr_pkg::SCALE_W-1:0] inv_scale_q;

	// Stage 1: input register
	logic                         valid_s1;
	logic [ptdr_pkg::MASK_W-1:0]  mask_s1;
	logic [ptdr_pkg::POS_W-1:0]   x_s1;
	logic [ptdr_pkg::POS_W-1:0]   y_s1;

	// Stage 2: output register
	logic                         valid_s2;
	ptdr_pkg::gesture_t           gesture_s2;
	logic [ptdr_pkg::COORD_W-1:0] from_x_s2;
	logic [ptdr_pkg::COORD_W-1:0] from_y_s2;
	logic [ptdr_pkg::COORD_W-1:0] to_x_s2;
	logic [ptdr_pkg::COORD_W-1:0] to_y_s2;

	// Gesture state
	phase_t                       phase_q;
	logic [ptdr_pkg::POS_W-1:0]   start_x_q;
	logic [ptdr_pkg::POS_W-1:0]   start_y_q;
	logic                         tap_pressed_q;
	logic [ptdr_pkg::POS_W-1:0]   last_x_q;
	logic [ptdr_pkg::POS_W-1:0]   last_y_q;

	// Next-state and decision signals
	phase_t                       phase_d;
	logic [ptdr_pkg::POS_W-1:0]   start_x_d;
	logic [ptdr_pkg::POS_W-1:0]   start_y_d;
	logic                         tap_pressed_d;
	logic                         ignore;
	logic                         down;
	logic                         drag_fire;
	logic                         tap_fire;
	logic                         update;

	// Unscaled result of the decision
	ptdr_pkg::gesture_t           gesture_d;
	logic [ptdr_pkg::POS_W-1:0]   from_x_d;
	logic [ptdr_pkg::POS_W-1:0]   from_y_d;
	logic [ptdr_pkg::POS_W-1:0]   to_x_d;
	logic [ptdr_pkg::POS_W-1:0]   to_y_d;

	// Stage enables: a stage loads when it is empty or its item moves on
	logic                         en1;
	logic                         en2;
	logic                         cfg_write;
	ptdr_pkg::reg_idx_t           reg_idx;

	// Scaler results
	logic [ptdr_pkg::COORD_W-1:0] from_x_sc;
	logic [ptdr_pkg::COORD_W-1:0] from_y_sc;
	logic [ptdr_pkg::COORD_W-1:0] to_x_sc;
	logic [ptdr_pkg::COORD_W-1:0] to_y_sc;

	assign en2      = !valid_s2 || m_tready;
	assign en1      = !valid_s1 || en2;
	assign s_tready = en1;

	// Configuration port
	assign pready    = 1'b1;
	assign reg_idx   = ptdr_pkg::reg_idx_t'(paddr[ptdr_pkg::REG_IDX_W+1:2]);
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= ptdr_pkg::SCREEN_WIDTH_RST;
			screen_height_q <= ptdr_pkg::SCREEN_HEIGHT_RST;
			inv_scale_q     <= ptdr_pkg::INV_SCALE_RST;
		end else if (cfg_write) begin
			case (reg_idx)
				ptdr_pkg::REG_SCREEN_WIDTH:  screen_width_q  <= pwdata[ptdr_pkg::POS_W-1:0];
				ptdr_pkg::REG_SCREEN_HEIGHT: screen_height_q <= pwdata[ptdr_pkg::POS_W-1:0];
				ptdr_pkg::REG_INV_SCALE:     inv_scale_q     <= pwdata[ptdr_pkg::SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			ptdr_pkg::REG_SCREEN_WIDTH:
				prdata = {{(32 - ptdr_pkg::POS_W){1'b0}}, screen_width_q};
			ptdr_pkg::REG_SCREEN_HEIGHT:
				prdata = {{(32 - ptdr_pkg::POS_W){1'b0}}, screen_height_q};
			ptdr_pkg::REG_INV_SCALE:
				prdata = {{(32 - ptdr_pkg::SCALE_W){1'b0}}, inv_scale_q};
			default:
				prdata = '0;
		endcase
	end

	// Stage 1: capture the event
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en1) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && en1) begin
			mask_s1 <= s_tdata[ptdr_pkg::MASK_W-1:0];
			x_s1    <= s_tdata[ptdr_pkg::MASK_W +: ptdr_pkg::POS_W];
			y_s1    <= s_tdata[ptdr_pkg::MASK_W + ptdr_pkg::POS_W +: ptdr_pkg::POS_W];
		end
	end

	// Event filter
	assign ignore = (mask_s1 > ptdr_pkg::MASK_W'(1)) || (x_s1 >= screen_width_q) ||
	                (y_s1 >= screen_height_q);
	assign down   = (mask_s1 == ptdr_pkg::MASK_W'(1));
	assign update = valid_s1 && en2 && !ignore;

	// Drag and tap machines; the tap machine only runs without a drag
	always_comb begin
		phase_d       = phase_q;
		start_x_d     = start_x_q;
		start_y_d     = start_y_q;
		tap_pressed_d = tap_pressed_q;
		drag_fire     = 1'b0;
		tap_fire      = 1'b0;
		if (down) begin
			case (phase_q)
				PH_PRESSED: begin
					if (x_s1 != start_x_q || y_s1 != start_y_q) begin
						phase_d = PH_MOVED;
					end
				end
				PH_MOVED: ;
				default: begin
					start_x_d = x_s1;
					start_y_d = y_s1;
					phase_d   = PH_PRESSED;
				end
			endcase
		end else begin
			drag_fire = (phase_q == PH_MOVED);
			phase_d   = PH_IDLE;
		end
		if (!drag_fire) begin
			if (x_s1 != last_x_q || y_s1 != last_y_q) begin
				tap_pressed_d = 1'b0;
			end else if (!tap_pressed_q) begin
				if (down) begin
					tap_pressed_d = 1'b1;
				end
			end else if (!down) begin
				tap_pressed_d = 1'b0;
				tap_fire      = 1'b1;
			end
		end
	end

	// Gesture state, updated as an event that is not ignored leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			start_x_q     <= '0;
			start_y_q     <= '0;
			tap_pressed_q <= 1'b0;
			last_x_q      <= '0;
			last_y_q      <= '0;
		end else if (update) begin
			phase_q       <= phase_d;
			start_x_q     <= start_x_d;
			start_y_q     <= start_y_d;
			tap_pressed_q <= tap_pressed_d;
			last_x_q      <= x_s1;
			last_y_q      <= y_s1;
		end
	end

	// Gesture and unscaled coordinates
	always_comb begin
		gesture_d = ptdr_pkg::GEST_NONE;
		from_x_d  = '0;
		from_y_d  = '0;
		to_x_d    = '0;
		to_y_d    = '0;
		if (!ignore && drag_fire) begin
			gesture_d = ptdr_pkg::GEST_DRAG;
			from_x_d  = start_x_q;
			from_y_d  = start_y_q;
			to_x_d    = x_s1;
			to_y_d    = y_s1;
		end else if (!ignore && tap_fire) begin
			gesture_d = ptdr_pkg::GEST_TAP;
			from_x_d  = x_s1;
			from_y_d  = y_s1;
			to_x_d    = x_s1;
			to_y_d    = y_s1;
		end
	end

	// Coordinate scaling
	ptdr_scale u_scale_from_x (.coord(from_x_d), .inv_scale(inv_scale_q), .scaled(from_x_sc));
	ptdr_scale u_scale_from_y (.coord(from_y_d), .inv_scale(inv_scale_q), .scaled(from_y_sc));
	ptdr_scale u_scale_to_x   (.coord(to_x_d),   .inv_scale(inv_scale_q), .scaled(to_x_sc));
	ptdr_scale u_scale_to_y   (.coord(to_y_d),   .inv_scale(inv_scale_q), .scaled(to_y_sc));

	// Stage 2: output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && en2) begin
			gesture_s2 <= gesture_d;
			from_x_s2  <= from_x_sc;
			from_y_s2  <= from_y_sc;
			to_x_s2    <= to_x_sc;
			to_y_s2    <= to_y_sc;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(8 * ptdr_pkg::OUT_BYTES - ptdr_pkg::OUT_W){1'b0}},
	                   to_y_s2, to_x_s2, from_y_s2, from_x_s2, gesture_s2};

	// Checks
	a_no_gesture_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && gesture_s2 == ptdr_pkg::GEST_NONE |->
			from_x_s2 == '0 && from_y_s2 == '0 && to_x_s2 == '0 && to_y_s2 == '0)
		else $error("coordinates reported without a gesture");

	a_tap_same_point: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && gesture_s2 == ptdr_pkg::GEST_TAP |->
			from_x_s2 == to_x_s2 && from_y_s2 == to_y_s2)
		else $error("tap with differing start and end");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && valid_s2 && !m_tready)
		else $error("input held off with room in the pipeline");

	a_drag_clears_phase: assert property (@(posedge clk) disable iff (!arst_n)
		update && drag_fire |=> phase_q == PH_IDLE)
		else $error("drag phase not cleared after a drag");

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the pointer tap/drag recogniser
// A short table of hand-picked pointer events is followed by randomised
// gesture sequences (taps, drags, broken sequences and junk events) under
// eight register settings. Every result item is checked field by field
// against the directed table or a behavioural predictor. Both sides idle and
// stall at random, and the output is held off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int unsigned MASK_W            = ptdr_pkg::MASK_W;
	localparam int unsigned POS_W             = ptdr_pkg::POS_W;
	localparam int unsigned SCALE_W           = ptdr_pkg::SCALE_W;
	localparam int unsigned COORD_W           = ptdr_pkg::COORD_W;
	localparam int unsigned GEST_W            = ptdr_pkg::GEST_W;
	localparam int unsigned FRAC_W            = ptdr_pkg::FRAC_W;
	localparam int unsigned PROD_W            = ptdr_pkg::PROD_W;
	localparam int unsigned REG_IDX_W         = ptdr_pkg::REG_IDX_W;

	localparam int unsigned CLK_HALF          = 10;
	localparam int unsigned N_PHASES          = 8;
	localparam int unsigned EVENTS_PER_PHASE  = 170;
	localparam int unsigned NOISE_ONLY_EVENTS = 40;
	localparam int unsigned DRAIN_CYCLES      = 8;
	localparam int unsigned HOLD_CYCLES       = 300;
	localparam int unsigned CYCLE_LIMIT       = 400000;
	localparam int unsigned MAX_PRINTED       = 40;
	localparam int unsigned TDATA_IN_W        = 8 * ptdr_pkg::IN_BYTES;
	localparam int unsigned TDATA_OUT_W       = 8 * ptdr_pkg::OUT_BYTES;

	typedef enum logic [1:0] {
		DRAG_IDLE    = 2'd0,
		DRAG_PRESSED = 2'd1,
		DRAG_MOVED   = 2'd2
	} drag_state_t;

	typedef struct packed {
		logic [MASK_W-1:0] mask;
		logic [POS_W-1:0]  x;
		logic [POS_W-1:0]  y;
	} ptr_event_t;

	typedef struct packed {
		ptdr_pkg::gesture_t kind;
		logic [COORD_W-1:0] fx;
		logic [COORD_W-1:0] fy;
		logic [COORD_W-1:0] tx;
		logic [COORD_W-1:0] ty;
	} gesture_res_t;

	typedef struct packed {
		logic [MASK_W-1:0]  mask;
		logic [POS_W-1:0]   x;
		logic [POS_W-1:0]   y;
		logic               known;
		ptdr_pkg::gesture_t kind;
		logic [COORD_W-1:0] fx;
		logic [COORD_W-1:0] fy;
		logic [COORD_W-1:0] tx;
		logic [COORD_W-1:0] ty;
	} dir_row_t;

	// Directed events from reset settings (1024 x 768, half scale).
	// known rows carry the expected item; the others go to the predictor.
	localparam dir_row_t DIRECTED [0:25] = '{
		// hover, press and release at the origin: tap at zero
		'{8'd0, 16'd0, 16'd0, 1'b1, ptdr_pkg::GEST_NONE, 17'd0, 17'd0, 17'd0, 17'd0},
		'{8'd1, 16'd0, 16'd0, 1'b1, ptdr_pkg::GEST_NONE, 17'd0, 17'd0, 17'd0, 17'd0},
		'{8'd0, 16'd0, 16'd0, 1'b1, ptdr_pkg::GEST_TAP, 17'd0, 17'd0, 17'd0, 17'd0},
		// tap at the far corner of the screen
		'{8'd0, 16'd1023, 16'd767, 1'b1, ptdr_pkg::GEST_NONE, 17'd0, 17'd0, 17'd0, 17'd0},
		'{8'd1, 16'd1023, 16'd767, 1'b1, ptdr_pkg::GEST_NONE, 17'd0, 17'd0, 17'd0, 17'd0},
		'{8'd0, 16'd1023, 16'd767, 1'b1, ptdr_pkg::GEST_TAP,
			17'd511, 17'd383, 17'd511, 17'd383},
		// drag from near the origin to the far corner
		'{8'd1, 16'd10, 16'd20, 1'b1, ptdr_pkg::GEST_NONE, 17'd0, 17'd0, 17'd0, 17'd0},
		'{8'd1, 16'd1023, 16'd767, 1'b1, ptdr_pkg::GEST_NONE, 17'd0, 17'd0, 17'd0, 17'd0},
		'{8'd0, 16'd1023, 16'd767, 1'b1, ptdr_pkg::GEST_DRAG,
			17'd5, 17'd10, 17'd511, 17'd383},
		// ignored: wide masks, off-screen positions, field maxima
		'{8'd2, 16'd0, 16'd0, 1'b1, ptdr_pkg::GEST_NONE, 17'd0, 17'd0, 17'd0, 17'd0},
		'{8'd255, 16'd5, 16'd5, 1'b1, ptdr_pkg::GEST_NONE, 17'd0, 17'd0, 17'd0, 17'd0},
		'{8'd1, 16'd1024, 16'd0, 1'b1, ptdr_pkg::GEST_NONE, 17'd0, 17'd0, 17'd0, 17'd0},
		'{8'd1, 16'd0, 16'd768, 1'b1, ptdr_pkg::GEST_NONE, 17'd0, 17'd0, 17'd0, 17'd0},
		'{8'd0, 16'd65535, 16'd65535, 1'b1, ptdr_pkg::GEST_NONE,
			17'd0, 17'd0, 17'd0, 17'd0},
		// a tap with an ignored event in the middle still counts
		'{8'd1, 16'd1023, 16'd767, 1'b0, ptdr_pkg::GEST_NONE, 17'd0, 17'd0, 17'd0, 17'd0},
		'{8'd3, 16'd1023, 16'd767, 1'b0, ptdr_pkg::GEST_NONE, 17'd0, 17'd0, 17'd0, 17'd0},
		'{8'd0, 16'd1023, 16'd767, 1'b1, ptdr_pkg::GEST_TAP,
			17'd511, 17'd383, 17'd511, 17'd383},
		// press held twice at one spot, then released: tap
		'{8'd1, 16'd100, 16'd100, 1'b0, ptdr_pkg::GEST_NONE, 17'd0, 17'd0, 17'd0, 17'd0},
		'{8'd1, 16'd100, 16'd100, 1'b0, ptdr_pkg::GEST_NONE, 17'd0, 17'd0, 17'd0, 17'd0},
		'{8'd0, 16'd100, 16'd100, 1'b1, ptdr_pkg::GEST_TAP, 17'd50, 17'd50, 17'd50, 17'd50},
		// one-pixel drag, scaled coordinates truncate
		'{8'd1, 16'd200, 16'd300, 1'b0, ptdr_pkg::GEST_NONE, 17'd0, 17'd0, 17'd0, 17'd0},
		'{8'd1, 16'd201, 16'd300, 1'b0, ptdr_pkg::GEST_NONE, 17'd0, 17'd0, 17'd0, 17'd0},
		'{8'd0, 16'd201, 16'd300, 1'b1, ptdr_pkg::GEST_DRAG,
			17'd100, 17'd150, 17'd100, 17'd150},
		// drag released away from the last position
		'{8'd1, 16'd201, 16'd300, 1'b0, ptdr_pkg::GEST_NONE, 17'd0, 17'd0, 17'd0, 17'd0},
		'{8'd1, 16'd202, 16'd300, 1'b0, ptdr_pkg::GEST_NONE, 17'd0, 17'd0, 17'd0, 17'd0},
		'{8'd0, 16'd201, 16'd300, 1'b0, ptdr_pkg::GEST_NONE, 17'd0, 17'd0, 17'd0, 17'd0}
	};

	// DUT signals
	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      s_tvalid;
	logic                      s_tready;
	// button_mask[7:0], pos_x[23:8], pos_y[39:24]
	logic [TDATA_IN_W-1:0]     s_tdata;
	logic                      m_tvalid;
	logic                      m_tready = 1'b0;
	// gesture[1:0], from_x[18:2], from_y[35:19], to_x[52:36], to_y[69:53]
	logic [TDATA_OUT_W-1:0]    m_tdata;
	logic                      psel;
	logic                      penable;
	logic                      pwrite;
	logic [REG_IDX_W+1:0]      paddr;
	logic [31:0]               pwdata;
	logic [31:0]               prdata;
	logic                      pready;

	// Predictor copy of registers and gesture state
	logic [POS_W-1:0]          cfg_width;
	logic [POS_W-1:0]          cfg_height;
	logic [SCALE_W-1:0]        cfg_inv;
	logic [POS_W-1:0]          prev_x;
	logic [POS_W-1:0]          prev_y;
	logic                      tap_armed;
	drag_state_t               drag_state;
	logic [POS_W-1:0]          anchor_x;
	logic [POS_W-1:0]          anchor_y;

	gesture_res_t              gesture_q[$];
	ptr_event_t                event_q[$];

	int unsigned               n_errors = 0;
	int unsigned               n_events = 0;
	int unsigned               n_ignored = 0;
	int unsigned               n_taps = 0;
	int unsigned               n_drags = 0;
	int unsigned               cycle_cnt = 0;
	int unsigned               tx_idle_pct = 0;
	int unsigned               rx_idle_pct = 0;
	int unsigned               hold_left = 0;
	bit                        stall_go = 1'b0;
	bit                        stall_taken = 1'b0;

	pointer_tap_drag_recognizer DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// 50 MHz clock
	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		if (n_errors < MAX_PRINTED)
			$display("%0t mismatch: %s got %0d expected %0d", $realtime, what, got, want);
		n_errors++;
	endtask

	// Coordinate times Q2.16 reciprocal, truncated, saturating at 17 bits
	function automatic logic [COORD_W-1:0] scaled(logic [POS_W-1:0] c);
		logic [PROD_W-1:0] prod;
		prod = PROD_W'(c) * PROD_W'(cfg_inv);
		if (prod[PROD_W-1])
			return ptdr_pkg::COORD_MAX;
		return prod[FRAC_W+COORD_W-1:FRAC_W];
	endfunction

	function automatic bit takes_effect(ptr_event_t ev);
		return ev.mask <= 8'd1 && ev.x < cfg_width && ev.y < cfg_height;
	endfunction

	// Gesture decision for one event; updates the predictor state
	function automatic gesture_res_t predict_gesture(ptr_event_t ev);
		gesture_res_t res;
		logic         down;
		logic         dragged;
		res = '0;
		if (!takes_effect(ev))
			return res;
		down = (ev.mask == 8'd1);
		dragged = 1'b0;
		// drag machine: latch the start on press, report on release after a move
		if (down) begin
			if (drag_state == DRAG_PRESSED) begin
				if (ev.x != anchor_x || ev.y != anchor_y)
					drag_state = DRAG_MOVED;
			end else if (drag_state != DRAG_MOVED) begin
				anchor_x = ev.x;
				anchor_y = ev.y;
				drag_state = DRAG_PRESSED;
			end
		end else begin
			dragged = (drag_state == DRAG_MOVED);
			drag_state = DRAG_IDLE;
		end
		// tap machine runs only when no drag is reported
		if (dragged) begin
			res.kind = ptdr_pkg::GEST_DRAG;
			res.fx = scaled(anchor_x);
			res.fy = scaled(anchor_y);
			res.tx = scaled(ev.x);
			res.ty = scaled(ev.y);
		end else if (ev.x != prev_x || ev.y != prev_y) begin
			tap_armed = 1'b0;
		end else if (!tap_armed) begin
			tap_armed = down;
		end else if (!down) begin
			tap_armed = 1'b0;
			res.kind = ptdr_pkg::GEST_TAP;
			res.fx = scaled(ev.x);
			res.fy = scaled(ev.y);
			res.tx = res.fx;
			res.ty = res.fy;
		end
		prev_x = ev.x;
		prev_y = ev.y;
		return res;
	endfunction

	// Random coordinate below lim, with the edges favoured; any value if lim is zero
	function automatic logic [POS_W-1:0] rand_coord(logic [POS_W-1:0] lim);
		if (lim == '0)
			return POS_W'($urandom);
		case ($urandom_range(7, 0))
			0: return '0;
			1: return lim - 1'b1;
			default: return POS_W'($urandom_range(32'(lim) - 1, 0));
		endcase
	endfunction

	// Junk event: fully random, or a wide mask on screen that the block ignores
	function automatic ptr_event_t junk_event();
		ptr_event_t ev;
		ev.mask = MASK_W'($urandom);
		ev.x = POS_W'($urandom);
		ev.y = POS_W'($urandom);
		if ($urandom_range(1, 0) == 0) begin
			ev.mask = MASK_W'($urandom_range(255, 2));
			ev.x = rand_coord(cfg_width);
			ev.y = rand_coord(cfg_height);
		end
		return ev;
	endfunction

	// Queue one gesture attempt: mostly well-formed taps and drags
	function automatic void queue_gesture();
		ptr_event_t ev;
		ev = '{8'd0, rand_coord(cfg_width), rand_coord(cfg_height)};
		case ($urandom_range(9, 0))
			0, 1, 2, 3: begin
				// sometimes hover first so the press lands on an unchanged spot
				if ($urandom_range(1, 0) != 0)
					event_q.push_back(ev);
				ev.mask = 8'd1;
				repeat ($urandom_range(2, 1))
					event_q.push_back(ev);
				if ($urandom_range(4, 0) == 0)
					event_q.push_back(junk_event());
				ev.mask = 8'd0;
				event_q.push_back(ev);
			end
			4, 5, 6: begin
				ev.mask = 8'd1;
				event_q.push_back(ev);
				repeat ($urandom_range(4, 0)) begin
					if ($urandom_range(2, 0) != 0) begin
						ev.x = rand_coord(cfg_width);
						ev.y = rand_coord(cfg_height);
					end
					event_q.push_back(ev);
					if ($urandom_range(5, 0) == 0)
						event_q.push_back(junk_event());
				end
				ev.mask = 8'd0;
				if ($urandom_range(1, 0) != 0) begin
					ev.x = rand_coord(cfg_width);
					ev.y = rand_coord(cfg_height);
				end
				event_q.push_back(ev);
			end
			7: begin
				// broken sequence: loose presses and releases
				repeat ($urandom_range(3, 1)) begin
					ev.mask = MASK_W'($urandom_range(1, 0));
					ev.x = rand_coord(cfg_width);
					ev.y = rand_coord(cfg_height);
					event_q.push_back(ev);
				end
			end
			default: event_q.push_back(junk_event());
		endcase
	endfunction

	// Offer one item, with random gaps; predict once it is taken
	task automatic send_event(ptr_event_t ev, logic use_want, gesture_res_t want);
		gesture_res_t pred;
		while ($urandom_range(99, 0) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= TDATA_IN_W'({ev.y, ev.x, ev.mask});
		do @(posedge clk); while (!s_tready);
		if (!takes_effect(ev))
			n_ignored++;
		pred = predict_gesture(ev);
		gesture_q.push_back(use_want ? want : pred);
		n_events++;
	endtask

	task automatic apb_write(ptdr_pkg::reg_idx_t idx, logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apb_readback(ptdr_pkg::reg_idx_t idx, logic [31:0] want);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== want)
			report_mismatch("register readback", prdata, want);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Drain the pipeline, then program and read back all three registers
	task automatic set_config(logic [POS_W-1:0] w, logic [POS_W-1:0] h, logic [SCALE_W-1:0] inv);
		s_tvalid <= 1'b0;
		while (gesture_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		apb_write(ptdr_pkg::REG_SCREEN_WIDTH, 32'(w));
		apb_write(ptdr_pkg::REG_SCREEN_HEIGHT, 32'(h));
		apb_write(ptdr_pkg::REG_INV_SCALE, 32'(inv));
		cfg_width = w;
		cfg_height = h;
		cfg_inv = inv;
		apb_readback(ptdr_pkg::REG_SCREEN_WIDTH, 32'(w));
		apb_readback(ptdr_pkg::REG_SCREEN_HEIGHT, 32'(h));
		apb_readback(ptdr_pkg::REG_INV_SCALE, 32'(inv));
	endtask

	task automatic check_result(logic [TDATA_OUT_W-1:0] d);
		gesture_res_t got;
		gesture_res_t want;
		got.kind = ptdr_pkg::gesture_t'(d[GEST_W-1:0]);
		got.fx = d[GEST_W +: COORD_W];
		got.fy = d[GEST_W + COORD_W +: COORD_W];
		got.tx = d[GEST_W + 2 * COORD_W +: COORD_W];
		got.ty = d[GEST_W + 3 * COORD_W +: COORD_W];
		if (gesture_q.size() == 0) begin
			report_mismatch("item with nothing outstanding, gesture", got.kind, 0);
		end else begin
			want = gesture_q.pop_front();
			if (want.kind == ptdr_pkg::GEST_TAP)
				n_taps++;
			if (want.kind == ptdr_pkg::GEST_DRAG)
				n_drags++;
			if (got.kind !== want.kind)
				report_mismatch("gesture", got.kind, want.kind);
			if (got.fx !== want.fx)
				report_mismatch("from_x", got.fx, want.fx);
			if (got.fy !== want.fy)
				report_mismatch("from_y", got.fy, want.fy);
			if (got.tx !== want.tx)
				report_mismatch("to_x", got.tx, want.tx);
			if (got.ty !== want.ty)
				report_mismatch("to_y", got.ty, want.ty);
		end
	endtask

	// Output side: check taken items, then pick next tready (long hold once)
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			check_result(m_tdata);
		if (stall_go && !stall_taken) begin
			stall_taken = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99, 0) >= rx_idle_pct);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d items outstanding", cycle_cnt,
				gesture_q.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Stimulus
	initial begin
		ptr_event_t   ev;
		gesture_res_t want;
		dir_row_t     row;
		int unsigned  counted;
		logic         noise_only;

		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		cfg_width = ptdr_pkg::SCREEN_WIDTH_RST;
		cfg_height = ptdr_pkg::SCREEN_HEIGHT_RST;
		cfg_inv = ptdr_pkg::INV_SCALE_RST;
		prev_x = '0;
		prev_y = '0;
		tap_armed = 1'b0;
		drag_state = DRAG_IDLE;
		anchor_x = '0;
		anchor_y = '0;
		tx_idle_pct = 29;
		rx_idle_pct = 54;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int i = 0; i < $size(DIRECTED); i++) begin
			row = DIRECTED[i];
			ev = '{row.mask, row.x, row.y};
			want = '{row.kind, row.fx, row.fy, row.tx, row.ty};
			send_event(ev, row.known, want);
		end

		// random phases, one register setting each
		for (int ph = 0; ph < N_PHASES; ph++) begin
			if (ph < 3) begin
				tx_idle_pct = 29;
				rx_idle_pct = 54;
			end else if (ph < 6) begin
				tx_idle_pct = 54;
				rx_idle_pct = 29;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			case (ph)
				0: set_config(16'hFFFF, 16'hFFFF, 18'd131072);
				1: set_config(16'd1, 16'd1, 18'd1);
				2: set_config(16'd0, 16'd0, 18'd32768);
				3: set_config(16'd1024, 16'd768, 18'h3FFFF);
				4: set_config(16'd640, 16'd480, 18'd0);
				5: set_config(16'hFFFF, 16'hFFFF, 18'h3FFFF);
				6: set_config(POS_W'($urandom_range(65535, 1)), POS_W'($urandom_range(65535, 1)),
					SCALE_W'($urandom_range(131072, 1)));
				default: set_config(ptdr_pkg::SCREEN_WIDTH_RST, ptdr_pkg::SCREEN_HEIGHT_RST,
					ptdr_pkg::INV_SCALE_RST);
			endcase
			if (ph == 6)
				stall_go = 1'b1;
			noise_only = (cfg_width == '0 || cfg_height == '0);
			event_q.delete();
			counted = 0;
			while (counted < (noise_only ? NOISE_ONLY_EVENTS : EVENTS_PER_PHASE)) begin
				if (event_q.size() == 0)
					queue_gesture();
				ev = event_q.pop_front();
				send_event(ev, 1'b0, '0);
				if (noise_only || takes_effect(ev))
					counted++;
			end
		end

		s_tvalid <= 1'b0;
		while (gesture_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d pointer events over %0d register settings, %0d of them ignored",
			n_events, N_PHASES + 1, n_ignored);
		$display("%0d taps and %0d drags among the checked items, %0d mismatches",
			n_taps, n_drags, n_errors);
		if (n_errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

@@ files.f @@
rtl/ptdr_pkg.sv
rtl/ptdr_scale.sv
rtl/pointer_tap_drag_recognizer.sv
bench/tb_top.sv
